// File: hdl/multiplicative_order_unit_assert.svh
// Assertion macros shared by the multiplicative order unit RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef MULTIPLICATIVE_ORDER_UNIT_ASSERT_SVH
`define MULTIPLICATIVE_ORDER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MOU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define MOU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/mou_pkg.sv
// Types shared by the multiplicative order unit: datapath operations,
// controller states and the command and status bundles between them.
package mou_pkg;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_XY,
        OP_GCD_STEP,
        OP_PHI_INIT,
        OP_DIV_VD,
        OP_V_STRIP,
        OP_V_PUSH_D,
        OP_CLR_STRIP,
        OP_INC_D,
        OP_DIV_RD,
        OP_RES_UPD_D,
        OP_DIV_RV,
        OP_RES_UPD_V,
        OP_FAC_INIT,
        OP_PUSH_V,
        OP_ORD_INIT,
        OP_DIV_CP,
        OP_TRIAL_SET,
        OP_DIV_BM,
        OP_POW_INIT,
        OP_MUL_ACC,
        OP_ACC_SET,
        OP_MUL_SQ,
        OP_SQ_SET,
        OP_ORD_NEXT,
        OP_OUT_FOUND,
        OP_OUT_NF,
        OP_OUT_ONE
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK,
        S_GCD_GO,
        S_GCD_WAIT,
        S_PHI_INIT,
        S_VD_GO,
        S_VD_WAIT,
        S_RES_GO,
        S_RES_WAIT,
        S_PFIN_GO,
        S_PFIN_WAIT,
        S_FAC_INIT,
        S_ORD_INIT,
        S_ORD_RD,
        S_ORD_DIV,
        S_ORD_DWAIT,
        S_PB_GO,
        S_PB_WAIT,
        S_POW,
        S_MA_WAIT,
        S_MS_GO,
        S_MS_WAIT,
        S_POW_END,
        S_DONE_F,
        S_NF,
        S_ONE,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic m_zero;
        logic m_one;
        logic x_one;
        logic y_zero;
        logic div_done;
        logic d_gt_q;
        logic r_zero;
        logic strip;
        logic v_gt1;
        logic i_lt_cnt;
        logic mul_done;
        logic e_zero;
        logic e_lsb;
    } dp_status_t;

endpackage

// File: hdl/mou_div.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; used by the multiplicative order datapath.
module mou_div #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quo,
    output logic [W-1:0] rem,
    output logic         done
);
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [W:0]       trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[W-2:0], fits};
            rem_reg <= fits ? W'(trial - {1'b0, dvs_reg}) : trial[W-1:0];
        end
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;
endmodule

// File: hdl/mou_mulmod.sv
// Modular multiplier by shift and add, one multiplier bit per cycle.
// Standalone; used by the multiplicative order datapath.
module mou_mulmod #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] op_a,
    input  logic [W-1:0] op_b,
    input  logic [W-1:0] modulus,
    output logic [W-1:0] prod,
    output logic         done
);
    logic [W-1:0] acc_reg;
    logic [W-1:0] x_reg;
    logic [W-1:0] y_reg;
    logic [W-1:0] m_reg;
    logic         busy_reg;
    logic         done_reg;

    // (a + b) mod m for a, b < m without overflow
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                             input logic [W-1:0] m);
        logic [W-1:0] gap;
        gap = m - b;
        if (a >= gap)
            return a - gap;
        return a + b;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && y_reg == '0)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            x_reg   <= op_a;
            y_reg   <= op_b;
            m_reg   <= modulus;
        end
        else if (busy_reg && y_reg != '0)
        begin
            if (y_reg[0])
                acc_reg <= add_mod(acc_reg, x_reg, m_reg);
            x_reg <= add_mod(x_reg, x_reg, m_reg);
            y_reg <= y_reg >> 1;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;
endmodule

// File: hdl/mou_dp.sv
// Datapath of the multiplicative order unit: operand registers, factor
// memory, divider and modular multiplier. Depends on mou_pkg, mou_div, mou_mulmod.
module mou_dp
    import mou_pkg::*;
#(
    parameter int W     = 32,
    parameter int MAX_F = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  dp_cmd_t      cmd,
    input  logic [W-1:0] base,
    input  logic [W-1:0] modulus,
    output dp_status_t   status,
    output logic [W-1:0] order,
    output logic         found
);
    localparam int CW = $clog2(MAX_F + 1);
    localparam int IW = $clog2(MAX_F);

    logic [W-1:0]  b_reg, m_reg, x_reg, y_reg, v_reg, res_reg, d_reg;
    logic [W-1:0]  cand_reg, trial_reg, pb_reg, acc_reg, e_reg;
    logic [W-1:0]  prime_q_reg, order_reg;
    logic          strip_reg, found_reg;
    logic [CW-1:0] cnt_reg, i_reg;
    logic [W-1:0]  primes [MAX_F];

    logic          div_start, mul_start, push, push_v;
    logic [W-1:0]  div_a, div_b, div_q, div_r, mul_a, mul_b, mul_p;
    logic          div_done, mul_done;

    always_comb
    begin
        div_start = 1'b0;
        div_a     = x_reg;
        div_b     = y_reg;
        unique case (cmd.op)
            OP_DIV_XY: div_start = 1'b1;
            OP_DIV_VD:
            begin
                div_start = 1'b1;
                div_a     = v_reg;
                div_b     = d_reg;
            end
            OP_DIV_RD:
            begin
                div_start = 1'b1;
                div_a     = res_reg;
                div_b     = d_reg;
            end
            OP_DIV_RV:
            begin
                div_start = 1'b1;
                div_a     = res_reg;
                div_b     = v_reg;
            end
            OP_DIV_CP:
            begin
                div_start = 1'b1;
                div_a     = cand_reg;
                div_b     = prime_q_reg;
            end
            OP_DIV_BM:
            begin
                div_start = 1'b1;
                div_a     = b_reg;
                div_b     = m_reg;
            end
            default: div_start = 1'b0;
        endcase
    end

    assign mul_start = (cmd.op == OP_MUL_ACC) || (cmd.op == OP_MUL_SQ);
    assign mul_a     = (cmd.op == OP_MUL_ACC) ? acc_reg : pb_reg;
    assign mul_b     = pb_reg;
    assign push      = (cmd.op == OP_V_PUSH_D) || (cmd.op == OP_PUSH_V);
    assign push_v    = (cmd.op == OP_PUSH_V);

    mou_div #(.W(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quo      (div_q),
        .rem      (div_r),
        .done     (div_done)
    );

    mou_mulmod #(.W(W)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (m_reg),
        .prod    (mul_p),
        .done    (mul_done)
    );

    // factor list: one write port, registered read at the order index
    always_ff @(posedge clk)
    begin
        if (push && cnt_reg < CW'(MAX_F))
            primes[cnt_reg[IW-1:0]] <= push_v ? v_reg : d_reg;
        prime_q_reg <= primes[i_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            i_reg     <= '0;
            strip_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_FAC_INIT)
                cnt_reg <= '0;
            else if (push && cnt_reg < CW'(MAX_F))
                cnt_reg <= cnt_reg + 1'b1;

            if (cmd.op == OP_ORD_INIT)
                i_reg <= '0;
            else if (cmd.op == OP_ORD_NEXT)
                i_reg <= i_reg + 1'b1;

            case (cmd.op) inside
                OP_V_STRIP, OP_V_PUSH_D:                     strip_reg <= 1'b1;
                OP_PHI_INIT, OP_FAC_INIT, OP_CLR_STRIP, OP_INC_D: strip_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op) inside
            OP_LOAD:
            begin
                b_reg <= base;
                m_reg <= modulus;
                x_reg <= base;
                y_reg <= modulus;
            end
            OP_GCD_STEP:
            begin
                x_reg <= y_reg;
                y_reg <= div_r;
            end
            OP_PHI_INIT:
            begin
                v_reg   <= m_reg;
                res_reg <= m_reg;
                d_reg   <= W'(2);
            end
            OP_V_STRIP, OP_V_PUSH_D: v_reg <= div_q;
            OP_INC_D:                d_reg <= d_reg + 1'b1;
            // res / d * (d - 1) == res - rem - quo
            OP_RES_UPD_D:
            begin
                res_reg <= res_reg - div_r - div_q;
                d_reg   <= d_reg + 1'b1;
            end
            OP_RES_UPD_V: res_reg <= res_reg - div_r - div_q;
            OP_FAC_INIT:
            begin
                v_reg    <= res_reg;
                cand_reg <= res_reg;
                d_reg    <= W'(2);
            end
            OP_TRIAL_SET: trial_reg <= div_q;
            OP_POW_INIT:
            begin
                pb_reg  <= div_r;
                acc_reg <= W'(1);
                e_reg   <= trial_reg;
            end
            OP_ACC_SET: acc_reg <= mul_p;
            OP_SQ_SET:
            begin
                pb_reg <= mul_p;
                e_reg  <= e_reg >> 1;
            end
            OP_ORD_NEXT:
            begin
                if (acc_reg == W'(1))
                    cand_reg <= trial_reg;
            end
            OP_OUT_FOUND:
            begin
                order_reg <= cand_reg;
                found_reg <= 1'b1;
            end
            OP_OUT_NF:
            begin
                order_reg <= '0;
                found_reg <= 1'b0;
            end
            OP_OUT_ONE:
            begin
                order_reg <= W'(1);
                found_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        status.m_zero   = (m_reg == '0);
        status.m_one    = (m_reg == W'(1));
        status.x_one    = (x_reg == W'(1));
        status.y_zero   = (y_reg == '0);
        status.div_done = div_done;
        status.d_gt_q   = (d_reg > div_q);
        status.r_zero   = (div_r == '0);
        status.strip    = strip_reg;
        status.v_gt1    = (v_reg > W'(1));
        status.i_lt_cnt = (i_reg < cnt_reg);
        status.mul_done = mul_done;
        status.e_zero   = (e_reg == '0);
        status.e_lsb    = e_reg[0];
    end

    assign order = order_reg;
    assign found = found_reg;
endmodule

// File: hdl/mou_ctrl.sv
// Controller state machine of the multiplicative order unit.
// Depends on mou_pkg; drives the datapath through dp_cmd_t.
module mou_ctrl
    import mou_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       in_ready,
    output logic       out_valid
);
    ctrl_state_t state_reg, state_next;
    logic        fac_reg, fac_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fac_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fac_reg   <= fac_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fac_next   = fac_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHK;
                end
            end
            S_CHK: state_next = status.m_zero ? S_NF : S_GCD_GO;
            S_GCD_GO:
            begin
                if (!status.y_zero)
                begin
                    cmd.op     = OP_DIV_XY;
                    state_next = S_GCD_WAIT;
                end
                else if (!status.x_one)
                    state_next = S_NF;
                else
                    state_next = status.m_one ? S_ONE : S_PHI_INIT;
            end
            S_GCD_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_GCD_STEP;
                    state_next = S_GCD_GO;
                end
            end
            S_PHI_INIT:
            begin
                cmd.op     = OP_PHI_INIT;
                fac_next   = 1'b0;
                state_next = S_VD_GO;
            end
            S_VD_GO:
            begin
                cmd.op     = OP_DIV_VD;
                state_next = S_VD_WAIT;
            end
            // shared trial-division loop for the totient and its factoring
            S_VD_WAIT:
            begin
                if (status.div_done)
                begin
                    if (!status.strip && status.d_gt_q)
                    begin
                        if (!fac_reg)
                            state_next = status.v_gt1 ? S_PFIN_GO : S_FAC_INIT;
                        else
                        begin
                            if (status.v_gt1)
                                cmd.op = OP_PUSH_V;
                            state_next = S_ORD_INIT;
                        end
                    end
                    else if (status.r_zero)
                    begin
                        cmd.op     = fac_reg ? OP_V_PUSH_D : OP_V_STRIP;
                        state_next = S_VD_GO;
                    end
                    else if (!fac_reg && status.strip)
                    begin
                        cmd.op     = OP_CLR_STRIP;
                        state_next = S_RES_GO;
                    end
                    else
                    begin
                        cmd.op     = OP_INC_D;
                        state_next = S_VD_GO;
                    end
                end
            end
            S_RES_GO:
            begin
                cmd.op     = OP_DIV_RD;
                state_next = S_RES_WAIT;
            end
            S_RES_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_RES_UPD_D;
                    state_next = S_VD_GO;
                end
            end
            S_PFIN_GO:
            begin
                cmd.op     = OP_DIV_RV;
                state_next = S_PFIN_WAIT;
            end
            S_PFIN_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_RES_UPD_V;
                    state_next = S_FAC_INIT;
                end
            end
            S_FAC_INIT:
            begin
                cmd.op     = OP_FAC_INIT;
                fac_next   = 1'b1;
                state_next = S_VD_GO;
            end
            S_ORD_INIT:
            begin
                cmd.op     = OP_ORD_INIT;
                state_next = S_ORD_RD;
            end
            // wait state for the registered factor memory read
            S_ORD_RD: state_next = status.i_lt_cnt ? S_ORD_DIV : S_DONE_F;
            S_ORD_DIV:
            begin
                cmd.op     = OP_DIV_CP;
                state_next = S_ORD_DWAIT;
            end
            S_ORD_DWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_TRIAL_SET;
                    state_next = S_PB_GO;
                end
            end
            S_PB_GO:
            begin
                cmd.op     = OP_DIV_BM;
                state_next = S_PB_WAIT;
            end
            S_PB_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_POW_INIT;
                    state_next = S_POW;
                end
            end
            S_POW:
            begin
                if (status.e_zero)
                    state_next = S_POW_END;
                else if (status.e_lsb)
                begin
                    cmd.op     = OP_MUL_ACC;
                    state_next = S_MA_WAIT;
                end
                else
                begin
                    cmd.op     = OP_MUL_SQ;
                    state_next = S_MS_WAIT;
                end
            end
            S_MA_WAIT:
            begin
                if (status.mul_done)
                begin
                    cmd.op     = OP_ACC_SET;
                    state_next = S_MS_GO;
                end
            end
            S_MS_GO:
            begin
                cmd.op     = OP_MUL_SQ;
                state_next = S_MS_WAIT;
            end
            S_MS_WAIT:
            begin
                if (status.mul_done)
                begin
                    cmd.op     = OP_SQ_SET;
                    state_next = S_POW;
                end
            end
            S_POW_END:
            begin
                cmd.op     = OP_ORD_NEXT;
                state_next = S_ORD_RD;
            end
            S_DONE_F:
            begin
                cmd.op     = OP_OUT_FOUND;
                state_next = S_OUT;
            end
            S_NF:
            begin
                cmd.op     = OP_OUT_NF;
                state_next = S_OUT;
            end
            S_ONE:
            begin
                cmd.op     = OP_OUT_ONE;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
endmodule

// File: hdl/multiplicative_order_unit.sv
// Multiplicative order unit: for each (base, modulus) word returns the smallest k > 0
// with base^k = 1 mod modulus, or found = 0 and order 0 when the modulus is zero or base
// and modulus are not coprime. One item at a time. Every step runs on one shared
// restoring divider and one shift-add modular multiplier. Work per item is the gcd steps
// and about sqrt(modulus) + sqrt(totient) trial divisions, plus, per prime factor of the
// totient, two divisions and a modular power of up to 2 * WIDTH products; the trial
// divisions up to the square roots dominate.
// Depends on mou_pkg, mou_ctrl, mou_dp and the assertion macro header.
`include "multiplicative_order_unit_assert.svh"

module multiplicative_order_unit
    import mou_pkg::*;
#(
    parameter int WIDTH       = 32,
    parameter int MAX_FACTORS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [((2*WIDTH+7)/8)*8-1:0]     s_tdata,   // base, modulus
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [((WIDTH+7)/8)*8-1:0]       m_tdata,   // order
    output logic                             m_tuser    // found
);
    localparam int OUT_W = ((WIDTH + 7) / 8) * 8;

    dp_cmd_t      cmd;
    dp_status_t   status;
    logic [WIDTH-1:0] order;
    logic         found;

    mou_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (s_tready),
        .out_valid (m_tvalid)
    );

    mou_dp #(.W(WIDTH), .MAX_F(MAX_FACTORS)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .base    (s_tdata[WIDTH-1:0]),
        .modulus (s_tdata[2*WIDTH-1:WIDTH]),
        .status  (status),
        .order   (order),
        .found   (found)
    );

    assign m_tdata = OUT_W'(order);
    assign m_tuser = found;

    `MOU_ASSERT_SAME(a_nf_zero, m_tvalid && !m_tuser, m_tdata == '0)
    `MOU_ASSERT_SAME(a_one_item, s_tvalid && s_tready, !m_tvalid)
    `MOU_ASSERT_NEXT(a_ready_after, m_tvalid && m_tready, s_tready && !m_tvalid)
endmodule
